[design/spsm_pkg.sv]
`timescale 1ns / 1ps
package spsm_pkg;
   localparam int BodyBytes = 4096;
   localparam int MaxSlots = 32;
   localparam int SlotW = 5;
   localparam int CntW = 6;
   localparam int LenW = 13;
   localparam logic [LenW-1:0] HEADER_BYTES = 13'd8;
   localparam logic [LenW-1:0] SLOT_BYTES = 13'd8;
   localparam logic [LenW-1:0] BODY_SIZE = 13'(BodyBytes);
   localparam logic [CntW-1:0] MAX_SLOTS_C = 6'(MaxSlots);

   localparam logic [2:0] OP_INIT    = 3'd0;
   localparam logic [2:0] OP_INSERT  = 3'd1;
   localparam logic [2:0] OP_DELETE  = 3'd2;
   localparam logic [2:0] OP_READ    = 3'd3;
   localparam logic [2:0] OP_COMPACT = 3'd4;
   localparam logic [2:0] OP_FIT     = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_PAGE_FULL = 3'd3;
   localparam logic [2:0] ST_DIR_FULL  = 3'd4;

   // one directory entry as stored
   typedef struct packed {
      logic [LenW-1:0] offset;
      logic [LenW-1:0] length;
      logic            deleted;
   } entry_type;

   // memory port request from the sequencer
   typedef struct packed {
      logic             rd_en;
      logic [SlotW-1:0] rd_addr;
      logic             wr_en;
      logic [SlotW-1:0] wr_addr;
      entry_type        wr_data;
   } mem_req_type;
endpackage

[design/spsm_dir_mem.sv]
`timescale 1ns / 1ps
module spsm_dir_mem (
   input  logic                 clock,
   input  spsm_pkg::mem_req_type req,
   output spsm_pkg::entry_type  rd_data
);
   spsm_pkg::entry_type mem [spsm_pkg::MaxSlots];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr];
      end
   end
endmodule

[design/slotted_page_space_manager_core.sv]
`timescale 1ns / 1ps
// initialize, unknown opcodes and argument errors are answered straight from idle;
// an in-range read or delete reads its directory entry first, then answers
// insert and fit query scan one entry a cycle until a deleted entry is found, then decide
// compact walks every slot, highest first, and gives one move result per live entry
// busy holds through the last result, so a new item is taken only after it has gone
// receiver cannot stall; synchronous active-high reset restores an empty page
module slotted_page_space_manager_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [4:0]  req_slot_number,
   input  logic [12:0] req_tuple_length,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_slot_result,
   output logic [12:0] rsp_source_offset,
   output logic [12:0] rsp_tuple_offset,
   output logic [12:0] rsp_tuple_bytes,
   output logic        rsp_would_not_fit,
   output logic [12:0] rsp_reclaimed,
   output logic [12:0] rsp_free_bytes,
   output logic [5:0]  rsp_slots_used,
   output logic [5:0]  rsp_live_tuples,
   output logic        rsp_last
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,  // read issued for scan index
      S_ONE   = 6'b000100,  // single entry read pending
      S_WALK  = 6'b001000,  // compact walk, reads pipelined
      S_DONE  = 6'b010000,  // emit final result
      S_DECIDE = 6'b100000  // insert or fit decision after scan
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]  op_ff, op_in;
   logic [4:0]  slot_ff, slot_in;
   logic [12:0] len_ff, len_in;
   logic [5:0]  dsize_ff, dsize_in;
   logic [5:0]  ttot_ff, ttot_in;
   logic [12:0] fstart_ff, fstart_in;
   logic [12:0] fend_ff, fend_in;
   logic [12:0] pack_ff, pack_in;
   logic [12:0] oldend_ff, oldend_in;
   // scan index: next slot to read; rd pending flags the data returning
   logic [5:0]  idx_ff, idx_in;
   logic        rdv_ff, rdv_in;
   logic [4:0]  rdslot_ff, rdslot_in;
   logic        found_ff, found_in;
   logic [4:0]  fslot_ff, fslot_in;

   // an item is taken only while idle with no result on the ports
   logic        accept;
   assign accept = start && !busy;

   spsm_pkg::mem_req_type mreq;
   spsm_pkg::entry_type   rdata;

   spsm_dir_mem u_mem (.clock(clock), .req(mreq), .rd_data(rdata));

   // result register
   logic        ov_ff, ov_in;
   logic [2:0]  ost_ff, ost_in;
   logic [4:0]  oslot_ff, oslot_in;
   logic [12:0] osrc_ff, osrc_in;
   logic [12:0] ooff_ff, ooff_in;
   logic [12:0] obytes_ff, obytes_in;
   logic        onf_ff, onf_in;
   logic [12:0] orecl_ff, orecl_in;
   logic        olast_ff, olast_in;
   logic [12:0] ofree_ff, ofree_in;
   logic [5:0]  oused_ff, oused_in;
   logic [5:0]  olive_ff, olive_in;

   logic [12:0] free_now;
   logic [13:0] need;
   logic        out_of_slots;

   always_comb begin
      free_now = (fend_in > fstart_in) ? fend_in - fstart_in : 13'd0;
   end

   always_comb begin
      logic [12:0] fcur;
      logic [12:0] newpk;
      logic [12:0] recl;
      fcur = (fend_ff > fstart_ff) ? fend_ff - fstart_ff : 13'd0;
      state_in = state_ff;
      op_in = op_ff; slot_in = slot_ff; len_in = len_ff;
      dsize_in = dsize_ff; ttot_in = ttot_ff; fstart_in = fstart_ff;
      fend_in = fend_ff; pack_in = pack_ff; oldend_in = oldend_ff;
      idx_in = idx_ff; rdv_in = 1'b0; rdslot_in = rdslot_ff;
      found_in = found_ff; fslot_in = fslot_ff;
      mreq = '0;
      ov_in = 1'b0; ost_in = spsm_pkg::ST_OK; oslot_in = '0; osrc_in = '0;
      ooff_in = '0; obytes_in = '0; onf_in = 1'b0; orecl_in = '0; olast_in = 1'b0;
      need = '0; out_of_slots = 1'b0;
      newpk = '0; recl = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_opcode; slot_in = req_slot_number; len_in = req_tuple_length;
               idx_in = '0; found_in = 1'b0; fslot_in = '0;
               case (req_opcode)
                  spsm_pkg::OP_INIT: begin
                     dsize_in = '0; ttot_in = '0; fstart_in = spsm_pkg::HEADER_BYTES;
                     fend_in = spsm_pkg::BODY_SIZE; pack_in = spsm_pkg::BODY_SIZE;
                     ov_in = 1'b1; olast_in = 1'b1;
                  end
                  spsm_pkg::OP_INSERT, spsm_pkg::OP_FIT: begin
                     if (req_opcode == spsm_pkg::OP_INSERT && req_tuple_length == '0) begin
                        ov_in = 1'b1; olast_in = 1'b1; ost_in = spsm_pkg::ST_INVALID;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  spsm_pkg::OP_DELETE, spsm_pkg::OP_READ: begin
                     if ({1'b0, req_slot_number} >= dsize_ff) begin
                        ov_in = 1'b1; olast_in = 1'b1; ost_in = spsm_pkg::ST_NOT_FOUND;
                     end else begin
                        mreq.rd_en = 1'b1; mreq.rd_addr = req_slot_number;
                        state_in = S_ONE;
                     end
                  end
                  spsm_pkg::OP_COMPACT: begin
                     pack_in = spsm_pkg::BODY_SIZE; oldend_in = fend_ff;
                     idx_in = dsize_ff;
                     state_in = S_WALK;
                  end
                  default: begin
                     ov_in = 1'b1; olast_in = 1'b1; ost_in = spsm_pkg::ST_INVALID;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // issue read of idx, check returning data of previous
            if (rdv_ff && rdata.deleted && !found_ff) begin
               found_in = 1'b1; fslot_in = rdslot_ff;
            end
            if (idx_ff < dsize_ff && !(rdv_ff && rdata.deleted) && !found_ff) begin
               mreq.rd_en = 1'b1; mreq.rd_addr = idx_ff[4:0];
               rdv_in = 1'b1; rdslot_in = idx_ff[4:0];
               idx_in = idx_ff + 6'd1;
            end else if (!rdv_ff || (rdv_ff && rdata.deleted) || found_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            need = {1'b0, len_ff} + (found_ff ? 14'd0 : {1'b0, spsm_pkg::SLOT_BYTES});
            out_of_slots = !found_ff && (dsize_ff >= spsm_pkg::MAX_SLOTS_C);
            ov_in = 1'b1; olast_in = 1'b1; state_in = S_IDLE;
            if (op_ff == spsm_pkg::OP_FIT) begin
               onf_in = ({1'b0, fcur} < need) || out_of_slots;
            end else if (out_of_slots) begin
               ost_in = spsm_pkg::ST_DIR_FULL;
            end else if (need > {1'b0, fcur}) begin
               ost_in = spsm_pkg::ST_PAGE_FULL;
            end else begin
               mreq.wr_en = 1'b1;
               mreq.wr_addr = found_ff ? fslot_ff : dsize_ff[4:0];
               mreq.wr_data.offset = fend_ff - len_ff;
               mreq.wr_data.length = len_ff;
               mreq.wr_data.deleted = 1'b0;
               oslot_in = mreq.wr_addr; ooff_in = fend_ff - len_ff;
               fend_in = fend_ff - len_ff;
               ttot_in = ttot_ff + 6'd1;
               if (!found_ff) begin
                  dsize_in = dsize_ff + 6'd1;
                  fstart_in = fstart_ff + spsm_pkg::SLOT_BYTES;
               end
            end
         end
         S_ONE: begin
            ov_in = 1'b1; olast_in = 1'b1; state_in = S_IDLE;
            if (rdata.deleted) begin
               ost_in = spsm_pkg::ST_INVALID;
            end else if (op_ff == spsm_pkg::OP_DELETE) begin
               mreq.wr_en = 1'b1; mreq.wr_addr = slot_ff;
               mreq.wr_data = rdata; mreq.wr_data.deleted = 1'b1;
               if (ttot_ff != '0) ttot_in = ttot_ff - 6'd1;
            end else begin
               ooff_in = rdata.offset; obytes_in = rdata.length;
            end
         end
         S_WALK: begin
            // returning entry: slot rdslot_ff
            if (rdv_ff && !rdata.deleted) begin
               newpk = (pack_ff >= rdata.length) ? pack_ff - rdata.length : 13'd0;
               pack_in = newpk;
               mreq.wr_en = 1'b1; mreq.wr_addr = rdslot_ff;
               mreq.wr_data = rdata; mreq.wr_data.offset = newpk;
               ov_in = 1'b1; oslot_in = rdslot_ff; osrc_in = rdata.offset;
               ooff_in = newpk; obytes_in = rdata.length;
            end
            if (idx_ff != '0) begin
               mreq.rd_en = 1'b1; mreq.rd_addr = 5'(idx_ff - 6'd1);
               rdv_in = 1'b1; rdslot_in = 5'(idx_ff - 6'd1);
               idx_in = idx_ff - 6'd1;
            end else if (!rdv_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            recl = (pack_ff >= oldend_ff) ? pack_ff - oldend_ff : 13'd0;
            fend_in = pack_ff;
            ov_in = 1'b1; olast_in = 1'b1; orecl_in = recl;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      ofree_in = free_now; oused_in = dsize_in; olive_in = ttot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ov_ff <= 1'b0; rdv_ff <= 1'b0;
         dsize_ff <= '0; ttot_ff <= '0; fstart_ff <= spsm_pkg::HEADER_BYTES;
         fend_ff <= spsm_pkg::BODY_SIZE; pack_ff <= spsm_pkg::BODY_SIZE;
         found_ff <= 1'b0; idx_ff <= '0;
      end else begin
         state_ff <= state_in; ov_ff <= ov_in; rdv_ff <= rdv_in;
         dsize_ff <= dsize_in; ttot_ff <= ttot_in; fstart_ff <= fstart_in;
         fend_ff <= fend_in; pack_ff <= pack_in;
         found_ff <= found_in; idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; slot_ff <= slot_in; len_ff <= len_in; oldend_ff <= oldend_in;
      rdslot_ff <= rdslot_in; fslot_ff <= fslot_in;
      ost_ff <= ost_in; oslot_ff <= oslot_in; osrc_ff <= osrc_in; ooff_ff <= ooff_in;
      obytes_ff <= obytes_in; onf_ff <= onf_in; orecl_ff <= orecl_in;
      olast_ff <= olast_in; ofree_ff <= ofree_in; oused_ff <= oused_in;
      olive_ff <= olive_in;
   end

   // sum of live tuple lengths: compact packs them tight against the page end,
   // so the free space after the walk is known before the first move goes out
   logic [12:0] live_sum_ff, live_sum_in;
   logic [12:0] free_final_move;
   always_comb begin
      live_sum_in = live_sum_ff;
      if (mreq.wr_en && state_ff == S_DECIDE) live_sum_in = live_sum_ff + len_ff;
      if (mreq.wr_en && state_ff == S_ONE) live_sum_in = live_sum_ff - rdata.length;
      if (state_ff == S_IDLE && accept && req_opcode == spsm_pkg::OP_INIT)
         live_sum_in = '0;
      free_final_move = (spsm_pkg::BODY_SIZE - live_sum_ff > fstart_ff) ?
                        spsm_pkg::BODY_SIZE - live_sum_ff - fstart_ff : 13'd0;
   end
   always_ff @(posedge clock) begin
      if (reset) live_sum_ff <= '0;
      else       live_sum_ff <= live_sum_in;
   end

   assign busy = (state_ff != S_IDLE) || ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_status = ost_ff;
   assign rsp_slot_result = oslot_ff;
   assign rsp_source_offset = osrc_ff;
   assign rsp_tuple_offset = ooff_ff;
   assign rsp_tuple_bytes = obytes_ff;
   assign rsp_would_not_fit = onf_ff;
   assign rsp_reclaimed = orecl_ff;
   // move results of compact report the free space after packing completes
   assign rsp_free_bytes = (op_ff == spsm_pkg::OP_COMPACT && !olast_ff) ?
                           free_final_move : ofree_ff;
   assign rsp_slots_used = oused_ff;
   assign rsp_live_tuples = olive_ff;
   assign rsp_last = olast_ff;

`ifndef NO_ASSERTIONS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while not busy");
   a_dsize: assert property (@(posedge clock) disable iff (reset)
      dsize_ff <= spsm_pkg::MAX_SLOTS_C) else $error("directory overflow");
   a_live: assert property (@(posedge clock) disable iff (reset)
      ttot_ff <= dsize_ff) else $error("live count above directory size");
`endif
endmodule
